// File: src/hfpm_pkg.sv
`timescale 1ns / 1ps
package hfpm_pkg;

   // Default geometry of the coordinate fields.
   localparam int COORD_BITS_DEF = 10;
   localparam int DEST_BITS_DEF  = 8;

   // Coefficient format: signed Q12.20 in a 32-bit word.
   localparam int COEF_W   = 32;
   localparam int Q_FRAC   = 20;
   localparam int NUM_COEF = 8;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // One in Q12.20.
   localparam logic [COEF_W-1:0] Q_ONE = COEF_W'(1) << Q_FRAC;

   // Register indexes in the configuration map.
   typedef enum logic [REG_IDX_W-1:0] {
      REG_A01 = 3'd0,
      REG_A02 = 3'd1,
      REG_A10 = 3'd2,
      REG_A11 = 3'd3,
      REG_A12 = 3'd4,
      REG_A20 = 3'd5,
      REG_A21 = 3'd6,
      REG_A22 = 3'd7
   } reg_idx_type;

   // Reset value of each coefficient register.
   function automatic logic [COEF_W-1:0] coef_reset(input reg_idx_type idx);
      logic [COEF_W-1:0] val;
      case (idx)
         REG_A11, REG_A22: val = Q_ONE;
         default:          val = '0;
      endcase
      return val;
   endfunction

   // Colour bytes carried alongside the arithmetic.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } color_type;

endpackage

// File: src/hfpm_req_if.sv
`timescale 1ns / 1ps
interface hfpm_req_if #(
   parameter int COORD_BITS = hfpm_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] src_col;
   logic [COORD_BITS-1:0] src_row;
   logic [7:0]            blue_in;
   logic [7:0]            green_in;
   logic [7:0]            red_in;

   modport source (output valid, src_col, src_row, blue_in, green_in, red_in,
                   input ready);
   modport sink   (input valid, src_col, src_row, blue_in, green_in, red_in,
                   output ready);
endinterface

// File: src/hfpm_rsp_if.sv
`timescale 1ns / 1ps
interface hfpm_rsp_if #(
   parameter int DEST_BITS = hfpm_pkg::DEST_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [DEST_BITS-1:0] dest_col;
   logic [DEST_BITS-1:0] dest_row;
   logic [7:0]           blue_out;
   logic [7:0]           green_out;
   logic [7:0]           red_out;
   logic                 range_flag;

   modport source (output valid, dest_col, dest_row, blue_out, green_out, red_out,
                   range_flag, input ready);
   modport sink   (input valid, dest_col, dest_row, blue_out, green_out, red_out,
                   range_flag, output ready);
endinterface

// File: src/hfpm_div_pipe.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per stage.
// One range stage comes first, then QB bit stages.
// over_out is set when the quotient does not fit in QB bits.
module hfpm_div_pipe #(
   parameter int SW = 45,
   parameter int QB = hfpm_pkg::DEST_BITS_DEF
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [SW-1:0] num_in,
   input  logic [SW-1:0] den_in,
   output logic [QB-1:0] quo_out,
   output logic          over_out
);
   localparam int WW = SW + QB;

   logic [SW-1:0] rem_ff [QB+1];
   logic [SW-1:0] den_ff [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic          over_ff [QB+1];

   // Range stage: the quotient overflows when num >= den * 2^QB.
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= num_in;
         den_ff[0]  <= den_in;
         quo_ff[0]  <= '0;
         over_ff[0] <= {{QB{1'b0}}, num_in} >= {den_in, {QB{1'b0}}};
      end
   end

   // Bit stages, most significant quotient bit first.
   for (genvar k = 1; k <= QB; k++) begin : g_bit
      localparam int B = QB - k;
      logic [WW-1:0] trial;
      logic [WW-1:0] rem_wide;
      logic          take;
      assign trial    = {{QB{1'b0}}, den_ff[k-1]} << B;
      assign rem_wide = {{QB{1'b0}}, rem_ff[k-1]};
      assign take     = rem_wide >= trial;
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= take ? SW'(rem_wide - trial) : rem_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= quo_ff[k-1] | (take ? (QB'(1) << B) : '0);
            over_ff[k] <= over_ff[k-1];
         end
      end
   end

   assign quo_out  = quo_ff[QB];
   assign over_out = over_ff[QB];
endmodule

// File: src/homography_forward_pixel_map.sv
`timescale 1ns / 1ps
// Channel  Role    Beat contents
// req      sink    src_col, src_row, blue_in, green_in, red_in
// rsp      source  dest_col, dest_row, blue_out, green_out, red_out, range_flag
// csr      APB     eight 32-bit Q12.20 coefficients at byte address 4*i
//
// One pixel is accepted every cycle unless rsp stalls. Beats pass stages 1-4,
// two restoring dividers (one quotient bit per stage) and the output register.
// The whole pipeline advances together; it freezes only while rsp holds a
// beat that is not taken, and req.ready is low exactly then.
// Synchronous reset clears the valid bits and loads the coefficient defaults.
module homography_forward_pixel_map #(
   parameter int COORD_BITS = hfpm_pkg::COORD_BITS_DEF,
   parameter int DEST_BITS  = hfpm_pkg::DEST_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   hfpm_req_if.sink   req,
   hfpm_rsp_if.source rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hfpm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hfpm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [hfpm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   localparam int CW = hfpm_pkg::COEF_W;
   localparam int PW = COORD_BITS + 1 + CW;   // product width
   localparam int SW = PW + 2;                // sum width
   localparam int LAT = DEST_BITS + 1;        // divider latency

   typedef struct packed {
      logic                zero;
      logic                neg_col;
      logic                neg_row;
      hfpm_pkg::color_type color;
   } side_type;

   // Configuration registers.
   logic [CW-1:0] coef_ff [hfpm_pkg::NUM_COEF];
   logic [hfpm_pkg::REG_IDX_W-1:0] csr_idx;
   logic csr_wr;

   assign csr_idx    = csr_paddr[hfpm_pkg::REG_IDX_W+1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = coef_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hfpm_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= hfpm_pkg::coef_reset(hfpm_pkg::reg_idx_type'(i));
         end
      end else if (csr_wr) begin
         coef_ff[csr_idx] <= csr_pwdata;
      end
   end

   // Global advance: the pipeline moves unless the output beat is stuck.
   logic rsp_valid_ff;
   logic enable;
   assign enable    = !rsp_valid_ff || rsp.ready;
   assign req.ready = enable;

   // Stage 1: capture the input beat.
   logic                  s1_valid_ff;
   logic [COORD_BITS-1:0] s1_x_ff, s1_y_ff;
   hfpm_pkg::color_type   s1_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_x_ff     <= req.src_col;
         s1_y_ff     <= req.src_row;
         s1_color_ff <= '{blue: req.blue_in, green: req.green_in, red: req.red_in};
      end
   end

   // Stage 2: the five coefficient products and the fixed x term.
   logic signed [PW-1:0] p01_ff, p10_ff, p11_ff, p20_ff, p21_ff;
   logic signed [PW-1:0] px_ff;
   logic signed [CW-1:0] c02_ff, c12_ff, c22_ff;
   logic                 s2_valid_ff;
   hfpm_pkg::color_type  s2_color_ff;
   logic signed [COORD_BITS:0] xs, ys;

   assign xs = $signed({1'b0, s1_x_ff});
   assign ys = $signed({1'b0, s1_y_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p01_ff <= ys * $signed(coef_ff[hfpm_pkg::REG_A01]);
         p10_ff <= xs * $signed(coef_ff[hfpm_pkg::REG_A10]);
         p11_ff <= ys * $signed(coef_ff[hfpm_pkg::REG_A11]);
         p20_ff <= xs * $signed(coef_ff[hfpm_pkg::REG_A20]);
         p21_ff <= ys * $signed(coef_ff[hfpm_pkg::REG_A21]);
         px_ff  <= $signed({{(PW-COORD_BITS){1'b0}}, s1_x_ff}) <<< hfpm_pkg::Q_FRAC;
         c02_ff <= $signed(coef_ff[hfpm_pkg::REG_A02]);
         c12_ff <= $signed(coef_ff[hfpm_pkg::REG_A12]);
         c22_ff <= $signed(coef_ff[hfpm_pkg::REG_A22]);
         s2_color_ff <= s1_color_ff;
      end
   end

   // Stage 3: the three projective sums, exact.
   logic signed [SW-1:0] phi_ff, psi_ff, omega_ff;
   logic                 s3_valid_ff;
   hfpm_pkg::color_type  s3_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         phi_ff   <= SW'(px_ff)  + SW'(p01_ff) + SW'(c02_ff);
         psi_ff   <= SW'(p10_ff) + SW'(p11_ff) + SW'(c12_ff);
         omega_ff <= SW'(p20_ff) + SW'(p21_ff) + SW'(c22_ff);
         s3_color_ff <= s2_color_ff;
      end
   end

   // Stage 4: magnitudes and quotient signs.
   logic [SW-1:0] phi_abs_ff, psi_abs_ff, omega_abs_ff;
   logic          s4_valid_ff;
   side_type      s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (enable) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         phi_abs_ff   <= phi_ff[SW-1]   ? SW'(-phi_ff)   : SW'(phi_ff);
         psi_abs_ff   <= psi_ff[SW-1]   ? SW'(-psi_ff)   : SW'(psi_ff);
         omega_abs_ff <= omega_ff[SW-1] ? SW'(-omega_ff) : SW'(omega_ff);
         s4_side_ff.zero    <= omega_ff == '0;
         s4_side_ff.neg_col <= phi_ff[SW-1] ^ omega_ff[SW-1];
         s4_side_ff.neg_row <= psi_ff[SW-1] ^ omega_ff[SW-1];
         s4_side_ff.color   <= s3_color_ff;
      end
   end

   // Dividers for column and row.
   logic [DEST_BITS-1:0] qcol, qrow;
   logic                 ocol, orow;

   hfpm_div_pipe #(.SW(SW), .QB(DEST_BITS)) u_div_col (
      .clock(clock), .enable(enable), .num_in(phi_abs_ff), .den_in(omega_abs_ff),
      .quo_out(qcol), .over_out(ocol)
   );

   hfpm_div_pipe #(.SW(SW), .QB(DEST_BITS)) u_div_row (
      .clock(clock), .enable(enable), .num_in(psi_abs_ff), .den_in(omega_abs_ff),
      .quo_out(qrow), .over_out(orow)
   );

   // Side data delay line matching the divider latency.
   logic     side_valid_ff [LAT];
   side_type side_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            side_valid_ff[i] <= 1'b0;
         end
      end else if (enable) begin
         side_valid_ff[0] <= s4_valid_ff;
         for (int i = 1; i < LAT; i++) begin
            side_valid_ff[i] <= side_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= s4_side_ff;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Clamp and flag. A negative nonzero quotient clamps to zero.
   side_type             tail;
   logic                 tail_valid;
   logic                 col_low, col_high, row_low, row_high;
   logic [DEST_BITS-1:0] col_in, row_in;
   logic                 flag_in;

   assign tail       = side_ff[LAT-1];
   assign tail_valid = side_valid_ff[LAT-1];
   assign col_low  = tail.neg_col && (ocol || qcol != '0);
   assign row_low  = tail.neg_row && (orow || qrow != '0);
   assign col_high = !tail.neg_col && ocol;
   assign row_high = !tail.neg_row && orow;

   always_comb begin
      col_in  = col_low ? '0 : (col_high ? '1 : qcol);
      row_in  = row_low ? '0 : (row_high ? '1 : qrow);
      flag_in = col_low || col_high || row_low || row_high;
      if (tail.zero) begin
         col_in  = '0;
         row_in  = '0;
         flag_in = 1'b1;
      end
   end

   // Output register.
   logic [DEST_BITS-1:0] dest_col_ff, dest_row_ff;
   logic                 range_flag_ff;
   hfpm_pkg::color_type  out_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= tail_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dest_col_ff   <= col_in;
         dest_row_ff   <= row_in;
         range_flag_ff <= flag_in;
         out_color_ff  <= tail.color;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.dest_col   = dest_col_ff;
   assign rsp.dest_row   = dest_row_ff;
   assign rsp.blue_out   = out_color_ff.blue;
   assign rsp.green_out  = out_color_ff.green;
   assign rsp.red_out    = out_color_ff.red;
   assign rsp.range_flag = range_flag_ff;

   // A stuck output beat must hold off new input.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !req.ready)
      else $error("input accepted while output stalled");

   // A zero divisor always reports the origin with the flag raised.
   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      enable && tail_valid && tail.zero |=>
         rsp.range_flag && rsp.dest_col == '0 && rsp.dest_row == '0)
      else $error("zero divisor not flagged");

   // A register write lands in the addressed coefficient.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> coef_ff[$past(csr_idx)] == $past(csr_pwdata))
      else $error("coefficient write lost");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("output valid after reset");
endmodule
